### rtl/core/pid_pkg.sv
package pid_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 12;
	localparam int ERROR_BITS_DEF     = 8;

	localparam int GAIN_W   = 16;
	localparam int ILIM_W   = 12;
	localparam int DBAND_W  = 7;
	localparam int SLIM_W   = 7;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// integrator state, holds +/- 4095
	localparam int SUM_W    = 13;

	localparam int STEER_W  = 8;
	localparam int PTERM_W  = 24;
	localparam int ITERM_W  = 29;
	localparam int DTERM_W  = 25;
	localparam int OUT_BITS = STEER_W + PTERM_W + ITERM_W + DTERM_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_LIM = 3'd5;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd819;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd41;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd819;
	localparam logic [ILIM_W-1:0]  INT_LIMIT_RST = 12'd480;
	localparam logic [DBAND_W-1:0] DEADZONE_RST  = 7'd0;
	localparam logic [SLIM_W-1:0]  STEER_LIM_RST = 7'd8;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [ILIM_W-1:0]  integral_limit;
		logic [DBAND_W-1:0] deadzone;
		logic [SLIM_W-1:0]  steer_max;
	} pid_cfg_t;

endpackage

### rtl/core/pid_err.sv
module pid_err #(
	parameter int ERROR_BITS = pid_pkg::ERROR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pid_pkg::pid_cfg_t            cfg,
	input  logic                         accept,
	input  logic                         opcode,
	input  logic signed [ERROR_BITS-1:0] track_error,
	output logic signed [ERROR_BITS-1:0] e_s1,
	output logic signed [ERROR_BITS:0]   diff_s1,
	output logic signed [pid_pkg::SUM_W-1:0] sum_s1
);

	localparam int EB    = ERROR_BITS;
	localparam int SW    = pid_pkg::SUM_W;
	localparam int ACC_W = ((EB > SW) ? EB : SW) + 1;
	localparam logic signed [EB:0] EMAX = (EB+1)'((1 << (EB - 1)) - 1);

	logic signed [SW-1:0]    sum_q;
	logic signed [EB-1:0]    prev_q;
	logic signed [EB:0]      neg;
	logic signed [EB-1:0]    e_sat;
	logic [EB-1:0]           mag;
	logic signed [EB-1:0]    e;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] lim;
	logic signed [ACC_W-1:0] acc_clamped;
	logic signed [SW-1:0]    sum_next;
	logic signed [EB:0]      diff;

	always_comb begin
		neg   = -((EB+1)'(track_error));
		e_sat = (neg > EMAX) ? EB'(EMAX) : EB'(neg);
		mag   = e_sat[EB-1] ? EB'(-e_sat) : EB'(e_sat);
		// zero small errors inside the dead band
		e     = (32'(mag) <= 32'(cfg.deadzone)) ? '0 : e_sat;
		acc   = ACC_W'(sum_q) + ACC_W'(e);
		lim   = ACC_W'($signed({1'b0, cfg.integral_limit}));
		if (acc > lim) begin
			acc_clamped = lim;
		end else if (acc < -lim) begin
			acc_clamped = -lim;
		end else begin
			acc_clamped = acc;
		end
		diff = (EB+1)'(e) - (EB+1)'(prev_q);
		if (opcode) begin
			e        = '0;
			sum_next = '0;
			diff     = '0;
		end else begin
			sum_next = SW'(acc_clamped);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (accept) begin
			sum_q  <= sum_next;
			prev_q <= e;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_s1    <= e;
			diff_s1 <= diff;
			sum_s1  <= sum_next;
		end
	end

endmodule

### rtl/core/pid_mul.sv
module pid_mul #(
	parameter int ERROR_BITS = pid_pkg::ERROR_BITS_DEF
) (
	input  logic                             clk,
	input  pid_pkg::pid_cfg_t                cfg,
	input  logic                             load,
	input  logic signed [ERROR_BITS-1:0]     e_s1,
	input  logic signed [ERROR_BITS:0]       diff_s1,
	input  logic signed [pid_pkg::SUM_W-1:0] sum_s1,
	output logic signed [pid_pkg::GAIN_W+ERROR_BITS:0]     p_s2,
	output logic signed [pid_pkg::GAIN_W+pid_pkg::SUM_W:0] i_s2,
	output logic signed [pid_pkg::GAIN_W+ERROR_BITS+1:0]   d_s2
);

	localparam int P_W = pid_pkg::GAIN_W + ERROR_BITS + 1;
	localparam int I_W = pid_pkg::GAIN_W + pid_pkg::SUM_W + 1;
	localparam int D_W = pid_pkg::GAIN_W + ERROR_BITS + 2;

	logic signed [P_W-1:0] p;
	logic signed [I_W-1:0] i;
	logic signed [D_W-1:0] d;

	always_comb begin
		p = P_W'($signed({1'b0, cfg.gain_p})) * P_W'(e_s1);
		i = I_W'($signed({1'b0, cfg.gain_i})) * I_W'(sum_s1);
		d = D_W'($signed({1'b0, cfg.gain_d})) * D_W'(diff_s1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p_s2 <= p;
			i_s2 <= i;
			d_s2 <= d;
		end
	end

endmodule

### rtl/core/pid_out.sv
module pid_out #(
	parameter int GAIN_FRAC_BITS = pid_pkg::GAIN_FRAC_BITS_DEF,
	parameter int ERROR_BITS     = pid_pkg::ERROR_BITS_DEF
) (
	input  logic                             clk,
	input  pid_pkg::pid_cfg_t                cfg,
	input  logic                             load,
	input  logic signed [pid_pkg::GAIN_W+ERROR_BITS:0]     p_s2,
	input  logic signed [pid_pkg::GAIN_W+pid_pkg::SUM_W:0] i_s2,
	input  logic signed [pid_pkg::GAIN_W+ERROR_BITS+1:0]   d_s2,
	output logic signed [pid_pkg::STEER_W-1:0] steer_q,
	output logic signed [pid_pkg::PTERM_W-1:0] p_term_q,
	output logic signed [pid_pkg::ITERM_W-1:0] i_term_q,
	output logic signed [pid_pkg::DTERM_W-1:0] d_term_q
);

	localparam int P_W  = pid_pkg::GAIN_W + ERROR_BITS + 1;
	localparam int I_W  = pid_pkg::GAIN_W + pid_pkg::SUM_W + 1;
	localparam int D_W  = pid_pkg::GAIN_W + ERROR_BITS + 2;
	localparam int M_W  = (P_W > I_W) ? ((P_W > D_W) ? P_W : D_W) : ((I_W > D_W) ? I_W : D_W);
	localparam int S_W  = M_W + 2;
	localparam int ST_W = pid_pkg::STEER_W;
	localparam int PT_W = pid_pkg::PTERM_W;
	localparam int IT_W = pid_pkg::ITERM_W;
	localparam int DT_W = pid_pkg::DTERM_W;
	localparam logic signed [S_W-1:0] HALF = S_W'(1) <<< (GAIN_FRAC_BITS - 1);

	logic signed [S_W-1:0] total;
	logic signed [S_W-1:0] rounded;
	logic signed [S_W-1:0] lim;
	logic signed [S_W-1:0] clamped;

	always_comb begin
		total   = S_W'(p_s2) + S_W'(i_s2) + S_W'(d_s2);
		// floor after adding one half
		rounded = (total + HALF) >>> GAIN_FRAC_BITS;
		lim     = S_W'($signed({1'b0, cfg.steer_max}));
		if (rounded > lim) begin
			clamped = lim;
		end else if (rounded < -lim) begin
			clamped = -lim;
		end else begin
			clamped = rounded;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			steer_q  <= ST_W'(clamped);
			p_term_q <= PT_W'(p_s2);
			i_term_q <= IT_W'(i_s2);
			d_term_q <= DT_W'(d_s2);
		end
	end

endmodule

### rtl/core/pid_steering_control.sv
// channel  | dir | signals                      | contents
// ---------+-----+------------------------------+------------------------------------------
// s_*      | in  | tvalid tready tdata tuser    | tdata: track_error; tuser: opcode
// m_*      | out | tvalid tready tdata          | tdata: steer, p_term, i_term, d_term
// cfg_*    | in  | wen idx wdata                | register writes, no read-back
//
// One request per cycle is accepted while s_tready is high; its result moves
// through the stage 1, stage 2 and output registers.
// Stage 1 updates the error sum and history, stage 2 runs the three gain multipliers,
// stage 3 adds, rounds and clamps into the output register.
// arst_n clears the valid bits, the integrator and the error history
// and presets the config registers. Each stage advances when the stage after it
// is empty or moving, so m_tready low only stalls once the pipeline is full.
module pid_steering_control #(
	parameter int GAIN_FRAC_BITS = pid_pkg::GAIN_FRAC_BITS_DEF,
	parameter int ERROR_BITS     = pid_pkg::ERROR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [ERROR_BITS-1:0] track_error, zero pad above
	input  logic [((ERROR_BITS + 7) / 8) * 8-1:0] s_tdata,
	// [0] opcode
	input  logic                                  s_tuser,

	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [7:0] steer, [31:8] p_term, [60:32] i_term, [85:61] d_term, zero pad above
	output logic [pid_pkg::OUT_TDATA_W-1:0]       m_tdata,

	input  logic                                  cfg_wen,
	input  logic [pid_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [pid_pkg::CFG_W-1:0]             cfg_wdata
);

	localparam int EB   = ERROR_BITS;
	localparam int PAD_W = pid_pkg::OUT_TDATA_W - pid_pkg::OUT_BITS;

	pid_pkg::pid_cfg_t cfg_q;

	logic v1_q;
	logic v2_q;
	logic ov_q;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic accept;

	logic signed [EB-1:0]                 e_s1;
	logic signed [EB:0]                   diff_s1;
	logic signed [pid_pkg::SUM_W-1:0]     sum_s1;
	logic signed [pid_pkg::GAIN_W+EB:0]   p_s2;
	logic signed [pid_pkg::GAIN_W+pid_pkg::SUM_W:0] i_s2;
	logic signed [pid_pkg::GAIN_W+EB+1:0] d_s2;
	logic signed [pid_pkg::STEER_W-1:0]   steer_q;
	logic signed [pid_pkg::PTERM_W-1:0]   p_term_q;
	logic signed [pid_pkg::ITERM_W-1:0]   i_term_q;
	logic signed [pid_pkg::DTERM_W-1:0]   d_term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= pid_pkg::GAIN_P_RST;
			cfg_q.gain_i         <= pid_pkg::GAIN_I_RST;
			cfg_q.gain_d         <= pid_pkg::GAIN_D_RST;
			cfg_q.integral_limit <= pid_pkg::INT_LIMIT_RST;
			cfg_q.deadzone       <= pid_pkg::DEADZONE_RST;
			cfg_q.steer_max      <= pid_pkg::STEER_LIM_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				pid_pkg::REG_GAIN_P:    cfg_q.gain_p <= cfg_wdata[pid_pkg::GAIN_W-1:0];
				pid_pkg::REG_GAIN_I:    cfg_q.gain_i <= cfg_wdata[pid_pkg::GAIN_W-1:0];
				pid_pkg::REG_GAIN_D:    cfg_q.gain_d <= cfg_wdata[pid_pkg::GAIN_W-1:0];
				pid_pkg::REG_INT_LIMIT: cfg_q.integral_limit <= cfg_wdata[pid_pkg::ILIM_W-1:0];
				pid_pkg::REG_DEADZONE:  cfg_q.deadzone <= cfg_wdata[pid_pkg::DBAND_W-1:0];
				pid_pkg::REG_STEER_LIM: cfg_q.steer_max <= cfg_wdata[pid_pkg::SLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// advance a stage when the one after it is empty or moving
	assign rdy3     = !ov_q || m_tready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= s_tvalid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				ov_q <= v2_q;
			end
		end
	end

	pid_err #(
		.ERROR_BITS(ERROR_BITS)
	) u_err (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.opcode     (s_tuser),
		.track_error($signed(s_tdata[EB-1:0])),
		.e_s1       (e_s1),
		.diff_s1    (diff_s1),
		.sum_s1     (sum_s1)
	);

	pid_mul #(
		.ERROR_BITS(ERROR_BITS)
	) u_mul (
		.clk    (clk),
		.cfg    (cfg_q),
		.load   (v1_q && rdy2),
		.e_s1   (e_s1),
		.diff_s1(diff_s1),
		.sum_s1 (sum_s1),
		.p_s2   (p_s2),
		.i_s2   (i_s2),
		.d_s2   (d_s2)
	);

	pid_out #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.ERROR_BITS    (ERROR_BITS)
	) u_out (
		.clk     (clk),
		.cfg     (cfg_q),
		.load    (v2_q && rdy3),
		.p_s2    (p_s2),
		.i_s2    (i_s2),
		.d_s2    (d_s2),
		.steer_q (steer_q),
		.p_term_q(p_term_q),
		.i_term_q(i_term_q),
		.d_term_q(d_term_q)
	);

	assign m_tvalid = ov_q;
	assign m_tdata  = {{PAD_W{1'b0}}, d_term_q, i_term_q, p_term_q, steer_q};

endmodule

### rtl/core/pid_chk.sv
module pid_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pid_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	logic [2:0] inflight_q;
	logic       in_hs;
	logic       out_hs;

	assign in_hs  = s_tvalid && s_tready;
	assign out_hs = m_tvalid && m_tready;

	// count requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_hs) - 3'(out_hs);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more requests in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("result without a request");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	a_zero_terms: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[85:8] == 78'd0 |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero steer from zero terms");

endmodule

bind pid_steering_control pid_chk u_pid_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

### dv/tb_pid_steering_control.sv
module tb_pid_steering_control;
	timeunit 1ns;
	timeprecision 1ps;

	import pid_pkg::*;

	localparam int FRAC     = GAIN_FRAC_BITS_DEF;
	localparam int ERR_W    = ERROR_BITS_DEF;
	localparam int LIMIT    = 100000;
	localparam int PHASES   = 8;
	localparam int PHASE_N  = 85;

	// fields from the highest bit down, as they sit in m_tdata
	typedef struct packed {
		logic [DTERM_W-1:0] d_term;
		logic [ITERM_W-1:0] i_term;
		logic [PTERM_W-1:0] p_term;
		logic [STEER_W-1:0] steer;
	} pid_result_t;

	class steer_checker;
		pid_cfg_t                  cfg;
		logic signed [SUM_W-1:0]   err_sum;
		logic signed [ERR_W-1:0]   prev_err;
		pid_result_t               steer_due[$];
		int                        mismatches;

		function new();
			cfg.gain_p         = GAIN_P_RST;
			cfg.gain_i         = GAIN_I_RST;
			cfg.gain_d         = GAIN_D_RST;
			cfg.integral_limit = INT_LIMIT_RST;
			cfg.deadzone       = DEADZONE_RST;
			cfg.steer_max      = STEER_LIM_RST;
			err_sum            = '0;
			prev_err           = '0;
			mismatches         = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_GAIN_P:    cfg.gain_p         = val[GAIN_W-1:0];
				REG_GAIN_I:    cfg.gain_i         = val[GAIN_W-1:0];
				REG_GAIN_D:    cfg.gain_d         = val[GAIN_W-1:0];
				REG_INT_LIMIT: cfg.integral_limit = val[ILIM_W-1:0];
				REG_DEADZONE:  cfg.deadzone       = val[DBAND_W-1:0];
				REG_STEER_LIM: cfg.steer_max      = val[SLIM_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return steer_due.size();
		endfunction

		// work out the result of one accepted request and queue it
		function void note_request(logic clear, logic [ERR_W-1:0] err);
			pid_result_t want;
			int          e;
			int          mag;
			int          acc;
			int          lim;
			longint      gp;
			longint      gi;
			longint      gd;
			longint      p;
			longint      i;
			longint      d;
			longint      st;
			longint      sl;

			want = '0;
			if (clear) begin
				err_sum  = '0;
				prev_err = '0;
			end else begin
				e = -int'($signed(err));
				if (e > (1 << (ERR_W - 1)) - 1)
					e = (1 << (ERR_W - 1)) - 1;
				mag = (e < 0) ? -e : e;
				if (mag <= int'(cfg.deadzone))
					e = 0;

				lim = int'(cfg.integral_limit);
				acc = int'(err_sum) + e;
				if (acc > lim)
					acc = lim;
				if (acc < -lim)
					acc = -lim;
				err_sum = acc[SUM_W-1:0];

				gp = cfg.gain_p;
				gi = cfg.gain_i;
				gd = cfg.gain_d;
				p  = gp * e;
				i  = gi * acc;
				d  = gd * (e - int'(prev_err));
				prev_err = e[ERR_W-1:0];

				// floor of (x + half) drops the fraction, rounding half up
				st = (p + i + d + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
				sl = cfg.steer_max;
				if (st < -sl)
					st = -sl;
				if (st > sl)
					st = sl;

				want.steer  = st[STEER_W-1:0];
				want.p_term = p[PTERM_W-1:0];
				want.i_term = i[ITERM_W-1:0];
				want.d_term = d[DTERM_W-1:0];
			end
			steer_due.push_back(want);
		endfunction

		function void flag(string field, longint want_v, longint got_v);
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			mismatches++;
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			pid_result_t got;
			pid_result_t want;

			got = data[OUT_BITS-1:0];
			if (steer_due.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, got %h",
					$time, got);
				mismatches++;
				return;
			end
			want = steer_due.pop_front();
			if (got.steer !== want.steer)
				flag("steer", $signed(want.steer), $signed(got.steer));
			if (got.p_term !== want.p_term)
				flag("p_term", $signed(want.p_term), $signed(got.p_term));
			if (got.i_term !== want.i_term)
				flag("i_term", $signed(want.i_term), $signed(got.i_term));
			if (got.d_term !== want.d_term)
				flag("d_term", $signed(want.d_term), $signed(got.d_term));
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	// [7:0] track_error
	logic [ERR_W-1:0]             s_tdata   = '0;
	// [0] opcode
	logic                         s_tuser   = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	// [7:0] steer, [31:8] p_term, [60:32] i_term, [85:61] d_term, zero pad above
	logic [OUT_TDATA_W-1:0]       m_tdata;
	logic                         cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_idx   = '0;
	logic [CFG_W-1:0]             cfg_wdata = '0;

	steer_checker sb = new();
	bit           quiet = 1'b0;
	int           drift = 0;
	int           cycles = 0;

	pid_steering_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(logic clear, logic [ERR_W-1:0] err);
		int gap;

		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= err;
		s_tuser  <= clear;
		do @(posedge clk); while (!s_tready);
		sb.note_request(clear, err);
	endtask

	// drop valid and hold until every request has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// junk goes into the bits above each register's width
	task automatic program_all(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
			logic [GAIN_W-1:0] gd, logic [ILIM_W-1:0] il, logic [DBAND_W-1:0] db,
			logic [SLIM_W-1:0] sl);
		logic [CFG_W-1:0] junk;

		junk = CFG_W'($urandom);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_INT_LIMIT, {junk[CFG_W-1:ILIM_W], il});
		write_reg(REG_DEADZONE, {junk[CFG_W-1:DBAND_W], db});
		write_reg(REG_STEER_LIM, {junk[DBAND_W-1:0], junk[CFG_W-1:DBAND_W+SLIM_W], sl});
		// index past the register list must change nothing
		write_reg(REG_STEER_LIM + 3'd1 + CFG_IDX_W'($urandom_range(0, 1)), junk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_random(int count);
		int               k;
		int               v;
		int               mag;
		logic             clear;

		for (k = 0; k < count; k++) begin
			clear = ($urandom_range(0, 29) == 0);
			if ($urandom_range(0, 15) == 0)
				drift = $urandom_range(0, 255) - 128;
			case ($urandom_range(0, 7))
				0: v = $urandom_range(0, 255) - 128;
				1: v = $urandom_range(0, 1) ? 127 : -128 + int'($urandom_range(0, 1));
				2: begin
					mag = int'(sb.cfg.deadzone) + int'($urandom_range(0, 1));
					v = $urandom_range(0, 1) ? mag : -mag;
				end
				default: v = drift + int'($urandom_range(0, 6)) - 3;
			endcase
			if (v > 127)
				v = 127;
			if (v < -128)
				v = -128;
			send_item(clear, v[ERR_W-1:0]);
		end
	endtask

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			int stall;

			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		// {opcode, track_error}
		logic [8:0] seq_rst [14] = '{9'h000, 9'h001, 9'h0ff, 9'h07f, 9'h080, 9'h080,
			9'h080, 9'h080, 9'h080, 9'h07f, 9'h07f, 9'h15a, 9'h080, 9'h000};
		logic [8:0] seq_band [7] = '{9'h0fb, 9'h005, 9'h0fa, 9'h006, 9'h080, 9'h1ff,
			9'h07f};
		int ph;
		int k;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: saturate the integrator, then clear it
		for (k = 0; k < 14; k++)
			send_item(seq_rst[k][8], seq_rst[k][7:0]);
		drain();

		// dead band edges with both limits at zero
		program_all(16'd4096, 16'hffff, 16'd2048, 12'd0, 7'd5, 7'd0);
		for (k = 0; k < 7; k++)
			send_item(seq_band[k][8], seq_band[k][7:0]);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_all(16'hffff, 16'hffff, 16'hffff, 12'hfff, 7'd0, 7'h7f);
				1: program_all(16'd0, 16'd0, 16'd0, 12'd0, 7'd0, 7'd0);
				2: program_all(16'hffff, 16'hffff, 16'hffff, 12'hfff, 7'h7f, 7'h7f);
				// half gain on P alone: every odd error lands on a half
				3: program_all(16'd2048, 16'd0, 16'd0, 12'd0, 7'd0, 7'h7f);
				default: program_all(
					GAIN_W'($urandom_range(0, 3) == 0 ?
						$urandom_range(0, 65535) : $urandom_range(0, 8191)),
					GAIN_W'($urandom_range(0, 3) == 0 ?
						$urandom_range(0, 65535) : $urandom_range(0, 1023)),
					GAIN_W'($urandom_range(0, 3) == 0 ?
						$urandom_range(0, 65535) : $urandom_range(0, 8191)),
					ILIM_W'($urandom_range(0, 3) == 0 ?
						$urandom_range(0, 4095) : $urandom_range(0, 600)),
					DBAND_W'($urandom_range(0, 3) == 0 ?
						$urandom_range(0, 127) : $urandom_range(0, 8)),
					SLIM_W'($urandom_range(0, 127)));
			endcase
			quiet = (ph % 3 == 1);
			run_random(PHASE_N);
			drain();
		end
		quiet = 1'b0;

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pid_pkg.sv
rtl/core/pid_err.sv
rtl/core/pid_mul.sv
rtl/core/pid_out.sv
rtl/core/pid_steering_control.sv
rtl/core/pid_chk.sv
dv/tb_pid_steering_control.sv
